### hdl/assert_macros.svh
// Assertion helpers, compiled out when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define QOA_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) \
    else $error("assertion failed");

// Trigger implies consequence in the following cycle.
`define QOA_ASSERT_NEXT(lbl, ck, rn, trig, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (trig) |=> (cons)) \
    else $error("assertion failed");

`else

`define QOA_ASSERT(lbl, ck, rn, prop)
`define QOA_ASSERT_NEXT(lbl, ck, rn, trig, cons)

`endif

`endif

### hdl/qoa_pkg.sv
package qoa_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 32;
  localparam int TABLE_LEN    = 40;
  localparam int IT_W         = $clog2(CORDIC_STEPS);
  localparam int TOL_W        = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd107374;
  // |c| << (FRAC_BITS-1) plus half the magnitude
  localparam int DIV_NW       = 32 + FRAC_BITS - 1;
  localparam int DIV_CW       = $clog2(DIV_NW);

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_ROT = 2'd1,
    KIND_MUL = 2'd2
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

  // long division, elaboration-time constants only
  function automatic logic [63:0] const_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = 64'd0;
    r = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q62, alternating series, truncated terms
  function automatic logic [63:0] atan_pow2(int i);
    logic [63:0] p;
    logic [63:0] acc;
    p = (64'd1 << 62) >> i;
    acc = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        if (k[0] == 1'b0) acc = acc + const_div(p, 64'(2 * k + 1));
        else acc = acc - const_div(p, 64'(2 * k + 1));
        p = p >> (2 * i);
      end
    end
    return acc;
  endfunction

  // atan(1/3) in Q62
  function automatic logic [63:0] atan_third();
    logic [63:0] p;
    logic [63:0] acc;
    p = const_div(64'd1 << 62, 64'd3);
    acc = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        if (k[0] == 1'b0) acc = acc + const_div(p, 64'(2 * k + 1));
        else acc = acc - const_div(p, 64'(2 * k + 1));
        p = const_div(p, 64'd3);
        p = const_div(p, 64'd3);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] isqrt_const(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // table holds atan in Q60
  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) t[i] = (atan_pow2(1) + atan_third()) >> 2;
      else t[i] = atan_pow2(i) >> 2;
    end
    return t;
  endfunction

  function automatic logic [63:0] build_gain();
    logic [63:0] k2;
    k2 = 64'd1 << 62;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i < TABLE_LEN && 2 * i <= 62)
        k2 = k2 - const_div(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt_const(k2) << 29;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();
  localparam logic signed [63:0] PI_Q60   = atan_pow2(1) + atan_third();
  localparam logic signed [63:0] GAIN_Q60 = build_gain();

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### hdl/qoa_if.sv
interface qoa_in_if;
  import qoa_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] operand_w;
  logic signed [31:0] angle;
  modport source (output valid, kind, vec_x, vec_y, vec_z, operand_w, angle, input ready);
  modport sink (input valid, kind, vec_x, vec_y, vec_z, operand_w, angle, output ready);
endinterface

interface qoa_out_if;
  import qoa_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               renormalized;
  modport source (output valid, out_x, out_y, out_z, out_w, renormalized, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, renormalized, output ready);
endinterface

### hdl/qoa_div.sv
// Restoring divider, one quotient bit per cycle.
module qoa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qoa_pkg::DIV_NW-1:0] num,
  input  logic [31:0]                den,
  output qoa_pkg::div_stat_t         stat,
  output logic [qoa_pkg::DIV_NW-1:0] quo
);
  import qoa_pkg::*;

  logic [DIV_NW-1:0] n_r;
  logic [31:0]       rem_r;
  logic [31:0]       den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [32:0]       rem_sh;
  logic              qbit;
  logic [31:0]       rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, n_r[DIV_NW-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r    <= num;
        den_r  <= den;
        rem_r  <= 32'd0;
        cnt_r  <= DIV_CW'(DIV_NW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        n_r   <= {n_r[DIV_NW-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = n_r;

endmodule

### hdl/quaternion_orientation_accumulator.sv
// One item at a time: a new item is taken only once the last result has been
// loaded into the output register. Renormalization adds a bit-serial square
// root and a division of each of the four components by the one-bit-per-cycle
// divider; the rotation kinds also run the CORDIC loop.
// Reset (rst_n, synchronous): quaternion to identity, tolerance to 107374,
// no result pending.
module quaternion_orientation_accumulator (
  input  logic                      clk,
  input  logic                      rst_n,
  qoa_in_if.sink                    in_ch,
  qoa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [qoa_pkg::TOL_W-1:0] cfg_wdata
);
  import qoa_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_TRIG, S_AXIS, S_LOAD, S_HAM, S_SQ,
    S_CHK, S_SQRT, S_DSTART, S_DWAIT, S_OUT
  } state_t;

  localparam logic signed [63:0] HALF_PI = PI_Q60 >>> 1;
  localparam logic signed [63:0] ONE30   = 64'sd1 <<< 30;
  localparam logic signed [63:0] RND30   = 64'sd1 <<< 29;
  localparam logic signed [63:0] RND_C   = 64'sd1 <<< (59 - FRAC_BITS);
  localparam logic signed [63:0] RND_H   = 64'sd1 <<< (FRAC_BITS - 3);
  localparam logic [63:0]        M2_ONE  = 64'd1 << (2 * FRAC_BITS - 2);

  state_t              state_r;
  logic [TOL_W-1:0]    tol_r;
  logic [1:0]          kind_r;
  logic signed [31:0]  orient_r [4];
  logic signed [31:0]  q_r [4];     // operand quaternion b
  logic signed [31:0]  res_r [4];   // Hamilton product result
  logic signed [31:0]  vec_r [3];
  logic signed [31:0]  s30_r;
  logic signed [63:0]  cx_r, cy_r, h_r;
  logic                neg_r;
  logic [IT_W-1:0]     it_r;
  logic [4:0]          step_r;
  logic signed [63:0]  acc_r;
  logic signed [63:0]  prod_r;
  logic [63:0]         m2_r;
  logic [63:0]         sv_r, sq_r, bit_r;
  logic [31:0]         mag_r;
  logic [1:0]          comp_r;
  logic                ren_r;
  logic                out_valid_r;
  logic signed [31:0]  out_x_r, out_y_r, out_z_r, out_w_r;
  logic                out_ren_r;

  // ---------------- angle prep: half angle in Q60, fold into +-pi/2
  logic signed [63:0] h_in, h_red;
  logic               neg_in;
  always_comb begin
    h_in   = 64'(in_ch.angle) <<< 31;
    neg_in = 1'b0;
    h_red  = h_in;
    if (h_in > HALF_PI) begin
      h_red  = h_in - PI_Q60;
      neg_in = 1'b1;
    end else if (h_in < -HALF_PI) begin
      h_red  = h_in + PI_Q60;
      neg_in = 1'b1;
    end
  end

  // ---------------- CORDIC rotation step
  logic signed [63:0] dx, dy, atan_i;
  always_comb begin
    dx     = cy_r >>> it_r;
    dy     = cx_r >>> it_r;
    atan_i = ATAN_TAB[it_r];
  end

  // ---------------- sine/cosine rounding
  logic signed [63:0] cxn, cyn, s_rnd, c_rnd;
  logic signed [31:0] s_clamp;
  always_comb begin
    cxn   = neg_r ? -cx_r : cx_r;
    cyn   = neg_r ? -cy_r : cy_r;
    s_rnd = (cyn + RND30) >>> 30;
    c_rnd = (cxn + RND_C) >>> (60 - FRAC_BITS);
    if (s_rnd > ONE30) s_clamp = 32'(ONE30);
    else if (s_rnd < -ONE30) s_clamp = 32'(-ONE30);
    else s_clamp = s_rnd[31:0];
  end

  // ---------------- Hamilton product term schedule
  // term t of component j: orient[(t+3)%4] * b[ham_b]; order w, x, y, z
  logic [3:0] ham_k;    // product being consumed
  logic [1:0] ham_j, ham_t;
  logic [3:0] iss_k;    // product being issued
  logic [1:0] iss_a, iss_b;

  function automatic logic [1:0] ham_b(logic [1:0] j, logic [1:0] t);
    logic [1:0] r;
    case ({j, t})
      4'b0000: r = 2'd0; 4'b0001: r = 2'd3; 4'b0010: r = 2'd2; 4'b0011: r = 2'd1;
      4'b0100: r = 2'd1; 4'b0101: r = 2'd2; 4'b0110: r = 2'd3; 4'b0111: r = 2'd0;
      4'b1000: r = 2'd2; 4'b1001: r = 2'd1; 4'b1010: r = 2'd0; 4'b1011: r = 2'd3;
      4'b1100: r = 2'd3; 4'b1101: r = 2'd0; 4'b1110: r = 2'd1; 4'b1111: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic ham_neg(logic [1:0] j, logic [1:0] t);
    logic r;
    case (j)
      2'd0:    r = (t == 2'd3);
      2'd1:    r = (t == 2'd1);
      2'd2:    r = (t == 2'd2);
      default: r = (t != 2'd0);
    endcase
    return r;
  endfunction

  logic signed [63:0] term, acc_sum;
  logic signed [31:0] ham_out;
  always_comb begin
    ham_k   = 4'(step_r - 5'd1);
    ham_j   = ham_k[3:2];
    ham_t   = ham_k[1:0];
    iss_k   = step_r[3:0];
    iss_a   = iss_k[1:0] + 2'd3;
    iss_b   = ham_b(iss_k[3:2], iss_k[1:0]);
    term    = prod_r >>> 2;
    acc_sum = ((ham_t == 2'd0) ? 64'sd0 : acc_r) + (ham_neg(ham_j, ham_t) ? -term : term);
    ham_out = sat32((acc_sum + RND_H) >>> (FRAC_BITS - 2));
  end

  // ---------------- shared multiplier, registered product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state_r)
      S_AXIS: begin
        if (step_r < 5'd3) mul_a = vec_r[step_r[1:0]];
        mul_b = s30_r;
      end
      S_HAM: begin
        mul_a = orient_r[iss_a];
        mul_b = q_r[iss_b];
      end
      S_SQ: begin
        mul_a = orient_r[step_r[1:0]];
        mul_b = orient_r[step_r[1:0]];
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic signed [31:0] axis_q;
  assign axis_q = sat32((prod_r + RND30) >>> 30);

  // ---------------- tolerance check
  logic [63:0] diff, tol_sc;
  logic        skip_norm;
  always_comb begin
    diff      = (m2_r > M2_ONE) ? m2_r - M2_ONE : M2_ONE - m2_r;
    tol_sc    = 64'(tol_r) << (FRAC_BITS - 2);
    skip_norm = (diff < tol_sc) || (m2_r == 64'd0);
  end

  // ---------------- bit-serial square root step
  logic [63:0] sq_trial, sq_nxt;
  logic        sq_ge;
  always_comb begin
    sq_trial = sq_r + bit_r;
    sq_ge    = (sv_r >= sq_trial);
    sq_nxt   = sq_ge ? (sq_r >> 1) + bit_r : sq_r >> 1;
  end

  // ---------------- divider, one component at a time
  logic signed [31:0] dcomp;
  logic [31:0]        dabs;
  logic [DIV_NW-1:0]  div_num, div_quo;
  logic               div_start;
  div_stat_t          div_st;
  logic signed [31:0] div_res;
  always_comb begin
    dcomp     = orient_r[comp_r];
    dabs      = dcomp[31] ? 32'(-dcomp) : dcomp;
    div_num   = (DIV_NW'(dabs) << (FRAC_BITS - 1)) + DIV_NW'(mag_r >> 1);
    div_start = (state_r == S_DSTART);
    if (!dcomp[31])
      div_res = (div_quo > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : div_quo[31:0];
    else
      div_res = (div_quo > DIV_NW'(32'h8000_0000)) ? 32'sh8000_0000 : -div_quo[31:0];
  end

  qoa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mag_r),
    .stat  (div_st),
    .quo   (div_quo)
  );

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
      orient_r[0] <= 32'sd0;
      orient_r[1] <= 32'sd0;
      orient_r[2] <= 32'sd0;
      orient_r[3] <= 32'(ONE30 >>> (30 - FRAC_BITS));
    end else begin
      if (cfg_we) tol_r <= cfg_wdata;
      // S_OUT handles its own drain and reload
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r   <= in_ch.kind;
            vec_r[0] <= in_ch.vec_x;
            vec_r[1] <= in_ch.vec_y;
            vec_r[2] <= in_ch.vec_z;
            step_r   <= 5'd0;
            case (in_ch.kind)
              KIND_SET, KIND_ROT: begin
                h_r     <= h_red;
                neg_r   <= neg_in;
                cx_r    <= GAIN_Q60;
                cy_r    <= 64'sd0;
                it_r    <= '0;
                state_r <= S_CORDIC;
              end
              KIND_MUL: begin
                q_r[0]  <= in_ch.vec_x;
                q_r[1]  <= in_ch.vec_y;
                q_r[2]  <= in_ch.vec_z;
                q_r[3]  <= in_ch.operand_w;
                state_r <= S_HAM;
              end
              default: begin
                // unused kind: report state as is
                ren_r   <= 1'b0;
                state_r <= S_OUT;
              end
            endcase
          end
        end

        S_CORDIC: begin
          if (!h_r[63]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            h_r  <= h_r - atan_i;
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            h_r  <= h_r + atan_i;
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_STEPS - 1)) state_r <= S_TRIG;
        end

        S_TRIG: begin
          s30_r   <= s_clamp;
          q_r[3]  <= sat32(c_rnd);
          step_r  <= 5'd0;
          state_r <= S_AXIS;
        end

        S_AXIS: begin
          // product issued at a step is registered in prod_r and written at the next step
          if (step_r != 5'd0) q_r[2'(step_r - 5'd1)] <= axis_q;
          if (step_r == 5'd3) begin
            step_r  <= 5'd0;
            state_r <= (kind_r == KIND_SET) ? S_LOAD : S_HAM;
          end else begin
            step_r <= step_r + 5'd1;
          end
        end

        S_HAM: begin
          if (step_r != 5'd0) begin
            acc_r <= acc_sum;
            if (ham_t == 2'd3) res_r[ham_j] <= ham_out;
          end
          if (step_r == 5'd16) state_r <= S_LOAD;
          else step_r <= step_r + 5'd1;
        end

        S_LOAD: begin
          for (int i = 0; i < 4; i++)
            orient_r[i] <= (kind_r == KIND_SET) ? q_r[i] : res_r[i];
          m2_r    <= 64'd0;
          step_r  <= 5'd0;
          state_r <= S_SQ;
        end

        S_SQ: begin
          if (step_r != 5'd0) m2_r <= m2_r + (64'(prod_r) >> 2);
          if (step_r == 5'd4) state_r <= S_CHK;
          else step_r <= step_r + 5'd1;
        end

        S_CHK: begin
          if (skip_norm) begin
            ren_r   <= 1'b0;
            state_r <= S_OUT;
          end else begin
            sv_r    <= m2_r;
            sq_r    <= 64'd0;
            bit_r   <= 64'd1 << 62;
            state_r <= S_SQRT;
          end
        end

        S_SQRT: begin
          if (sq_ge) sv_r <= sv_r - sq_trial;
          sq_r  <= sq_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            mag_r   <= sq_nxt[31:0];
            comp_r  <= 2'd0;
            state_r <= S_DSTART;
          end
        end

        S_DSTART: state_r <= S_DWAIT;

        S_DWAIT: begin
          if (div_st.done) begin
            orient_r[comp_r] <= div_res;
            if (comp_r == 2'd3) begin
              ren_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DSTART;
            end
          end
        end

        S_OUT: begin
          // output register frees the input side once loaded
          if (!out_valid_r || out_ch.ready) begin
            out_x_r     <= orient_r[0];
            out_y_r     <= orient_r[1];
            out_z_r     <= orient_r[2];
            out_w_r     <= orient_r[3];
            out_ren_r   <= ren_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_x        = out_x_r;
  assign out_ch.out_y        = out_y_r;
  assign out_ch.out_z        = out_z_r;
  assign out_ch.out_w        = out_w_r;
  assign out_ch.renormalized = out_ren_r;

  // ---------------- checks
  `QOA_ASSERT(a_div_owned, clk, rst_n, !div_st.busy || state_r == S_DWAIT)
  `QOA_ASSERT(a_div_done, clk, rst_n, !div_st.done || state_r == S_DWAIT)
  `QOA_ASSERT_NEXT(a_out_load, clk, rst_n, state_r == S_OUT && (!out_valid_r || out_ch.ready), out_valid_r && state_r == S_IDLE)
  `QOA_ASSERT_NEXT(a_out_drain, clk, rst_n, out_valid_r && out_ch.ready && state_r != S_OUT, !out_valid_r)

endmodule

### bench/qoa_tb_if.sv
`timescale 1ns / 1ps

// Bench-side mirror of the block's channel interfaces is not needed: the
// block's own interfaces (qoa_in_if, qoa_out_if) are instantiated directly.
// This file holds the checker-facing helper type used by orientation_checker.
package qoa_tb_pkg;
  import qoa_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               renorm;
  } orient_result_t;
endpackage

### bench/orientation_checker.sv
`timescale 1ns / 1ps

module orientation_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  qoa_in_if                         in_ch,
  qoa_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [qoa_pkg::TOL_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);
  import qoa_pkg::*;
  import qoa_tb_pkg::*;

  logic signed [31:0] ori_x, ori_y, ori_z, ori_w;
  logic [TOL_W-1:0]   tolerance;
  orient_result_t     expected_q[$];
  logic signed [63:0] pi_q60, gain_q60;
  logic [63:0]        atan_q62[40];

  assign pending = expected_q.size();

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] atan_recip(logic [63:0] n);
    logic [63:0] p, acc, k;
    p = (64'd1 << 62) / n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      if (k[0] == 1'b0) acc = acc + p / (2 * k + 1);
      else acc = acc - p / (2 * k + 1);
      p = p / n;
      p = p / n;
      k++;
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] k2;
    k2 = 64'd1 << 62;
    atan_q62[0] = atan_recip(2) + atan_recip(3);
    for (int i = 1; i < 40; i++) atan_q62[i] = atan_recip(64'd1 << i);
    pi_q60 = atan_q62[0];
    for (int i = 0; i < CORDIC_STEPS && i < 40; i++)
      if (2 * i <= 62) k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
    gain_q60 = int_sqrt(k2) << 29;
  end

  // axis-angle pair to rotation quaternion
  function automatic void rotor(input logic signed [31:0] ax, ay, az, ang,
                                output logic signed [31:0] q[4]);
    logic signed [63:0] h, cx, cy, dx, dy, a, s30, c;
    logic flip;
    h = 64'(ang) * (64'sd1 <<< 31);
    cx = gain_q60;
    cy = 0;
    flip = 0;
    if (h > (pi_q60 >>> 1)) begin
      h = h - pi_q60;
      flip = 1;
    end else if (h < -(pi_q60 >>> 1)) begin
      h = h + pi_q60;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 40; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      a = atan_q62[i] >> 2;
      if (h >= 0) begin
        cx = cx - dx; cy = cy + dy; h = h - a;
      end else begin
        cx = cx + dx; cy = cy - dy; h = h + a;
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    s30 = round_shift(cy, 30);
    if (s30 > (64'sd1 <<< 30)) s30 = 64'sd1 <<< 30;
    if (s30 < -(64'sd1 <<< 30)) s30 = -(64'sd1 <<< 30);
    c = round_shift(cx, 60 - FRAC_BITS);
    q[0] = clamp32(round_shift(64'(ax) * s30, 30));
    q[1] = clamp32(round_shift(64'(ay) * s30, 30));
    q[2] = clamp32(round_shift(64'(az) * s30, 30));
    q[3] = clamp32(c);
  endfunction

  function automatic logic signed [63:0] hterm(logic signed [31:0] a, b);
    return floor_shift(64'(a) * 64'(b), 2);
  endfunction

  function automatic void hamilton(input logic signed [31:0] b[4]);
    logic signed [31:0] x, y, z, w;
    x = ori_x; y = ori_y; z = ori_z; w = ori_w;
    ori_x = clamp32(round_shift(hterm(w, b[0]) + hterm(x, b[3]) + hterm(y, b[2])
                                - hterm(z, b[1]), FRAC_BITS - 2));
    ori_y = clamp32(round_shift(hterm(w, b[1]) - hterm(x, b[2]) + hterm(y, b[3])
                                + hterm(z, b[0]), FRAC_BITS - 2));
    ori_z = clamp32(round_shift(hterm(w, b[2]) + hterm(x, b[1]) - hterm(y, b[0])
                                + hterm(z, b[3]), FRAC_BITS - 2));
    ori_w = clamp32(round_shift(hterm(w, b[3]) - hterm(x, b[0]) - hterm(y, b[1])
                                - hterm(z, b[2]), FRAC_BITS - 2));
  endfunction

  function automatic logic [63:0] sq_q(logic signed [31:0] c);
    logic signed [63:0] p;
    p = 64'(c) * 64'(c);
    return 64'(p) >> 2;
  endfunction

  function automatic logic signed [31:0] scale_by(logic signed [31:0] c, logic [63:0] mag);
    logic [63:0] m, q;
    m = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = ((m << (FRAC_BITS - 1)) + mag / 2) / mag;
    return clamp32(c < 0 ? -$signed(q) : $signed(q));
  endfunction

  function automatic logic renormalize();
    logic [63:0] m2, one, tol, diff, mag;
    m2 = sq_q(ori_x) + sq_q(ori_y) + sq_q(ori_z) + sq_q(ori_w);
    one = 64'd1 << (2 * FRAC_BITS - 2);
    tol = 64'(tolerance) << (FRAC_BITS - 2);
    diff = (m2 > one) ? m2 - one : one - m2;
    if (diff < tol || m2 == 0) return 1'b0;
    mag = int_sqrt(m2);
    ori_x = scale_by(ori_x, mag);
    ori_y = scale_by(ori_y, mag);
    ori_z = scale_by(ori_z, mag);
    ori_w = scale_by(ori_w, mag);
    return 1'b1;
  endfunction

  function automatic orient_result_t predict_update(logic [1:0] kind,
      logic signed [31:0] vx, vy, vz, vw, ang);
    logic signed [31:0] q[4];
    orient_result_t r;
    r.renorm = 0;
    case (kind)
      KIND_SET: begin
        rotor(vx, vy, vz, ang, q);
        ori_x = q[0]; ori_y = q[1]; ori_z = q[2]; ori_w = q[3];
        r.renorm = renormalize();
      end
      KIND_ROT: begin
        rotor(vx, vy, vz, ang, q);
        hamilton(q);
        r.renorm = renormalize();
      end
      KIND_MUL: begin
        q[0] = vx; q[1] = vy; q[2] = vz; q[3] = vw;
        hamilton(q);
        r.renorm = renormalize();
      end
      default: ;
    endcase
    r.x = ori_x; r.y = ori_y; r.z = ori_z; r.w = ori_w;
    return r;
  endfunction

  always @(posedge clk) begin
    orient_result_t got, want;
    if (!rst_n) begin
      ori_x <= 0; ori_y <= 0; ori_z <= 0;
      ori_w <= 32'sd1 <<< FRAC_BITS;
      tolerance <= TOL_RESET;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) tolerance <= cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(predict_update(in_ch.kind, in_ch.vec_x, in_ch.vec_y,
                                            in_ch.vec_z, in_ch.operand_w, in_ch.angle));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w,
                out_ch.renormalized};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected transfer on result channel");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch exp x=%0d y=%0d z=%0d w=%0d r=%0b got %0d %0d %0d %0d %0b",
                       want.x, want.y, want.z, want.w, want.renorm,
                       got.x, got.y, got.z, got.w, got.renorm);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qoa_pkg::*;

  localparam int ONE_Q30 = 1 << 30;
  // Q4.28 radians
  localparam int PI_Q28 = 843314857;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  int fail_count;
  int pending;
  logic quiet;       // no idling in the final stretch
  logic hold_sink;   // long receiver hold-off requested

  qoa_in_if  in_ch ();
  qoa_out_if out_ch ();

  quaternion_orientation_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  orientation_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung regression.
  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ch.ready <= 0;
        repeat (2000) @(negedge clk);
        out_ch.ready <= 1;
        wait (!hold_sink);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_ch.ready <= 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Offers one item and holds it until the transfer; called at a falling edge.
  task automatic send_item(logic [1:0] kind, logic signed [31:0] vx, vy, vz, vw, ang);
    in_ch.valid <= 1;
    in_ch.kind <= kind;
    in_ch.vec_x <= vx;
    in_ch.vec_y <= vy;
    in_ch.vec_z <= vz;
    in_ch.operand_w <= vw;
    in_ch.angle <= ang;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  // Mostly near-unit values, sometimes full-range noise or an extreme value.
  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return rand_word();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2 * ONE_Q30)) - ONE_Q30;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_angle();
    if ($urandom_range(0, 7) == 0) return rand_word();
    return $signed($urandom_range(0, 4 * PI_Q28)) - 2 * PI_Q28;
  endfunction

  task automatic random_item();
    logic [1:0] k;
    k = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    send_item(k, rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_angle());
  endtask

  // Register writes only with the block drained; pause covers its latency.
  task automatic set_tolerance(logic [TOL_W-1:0] v);
    in_ch.valid <= 0;
    wait (pending == 0);
    repeat (400) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [TOL_W-1:0] tol_set[5];
    tol_set = '{31'd0, 31'd1073741824, 31'h7FFF_FFFF, 31'd107374, 31'd5000};
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    quiet = 0;
    hold_sink = 0;
    in_ch.valid = 0;
    in_ch.kind = 0;
    in_ch.vec_x = 0;
    in_ch.vec_y = 0;
    in_ch.vec_z = 0;
    in_ch.operand_w = 0;
    in_ch.angle = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, every kind, unused kind, zero magnitude, wrapped angles.
    send_item(KIND_MUL, 0, 0, 0, ONE_Q30, 0);
    send_item(2'd3, 32'sh7FFF_FFFF, 0, 0, 0, 0);
    send_item(KIND_SET, ONE_Q30, 0, 0, 32'sh7FFF_FFFF, PI_Q28 / 2);
    send_item(KIND_ROT, 0, ONE_Q30, 0, 0, PI_Q28);
    send_item(KIND_ROT, 0, 0, ONE_Q30, 0, -PI_Q28);
    send_item(KIND_SET, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF);
    send_item(KIND_SET, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000);
    send_item(KIND_MUL, 0, 0, 0, 0, 32'sh7FFF_FFFF);
    send_item(KIND_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_item(KIND_SET, 0, 0, 0, 0, 0);
    send_item(KIND_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_item(KIND_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 32'sh7FFF_FFFF, -1);
    send_item(KIND_ROT, ONE_Q30, ONE_Q30, ONE_Q30, -1, 1);
    send_item(2'd3, -1, -1, -1, -1, -1);

    // Random phases through tolerance settings, extremes included.
    foreach (tol_set[p]) begin
      set_tolerance(tol_set[p]);
      for (int i = 0; i < 300; i++) random_item();
      if (p == 1) begin
        // sender pause until drained
        in_ch.valid <= 0;
        wait (pending == 0);
        @(negedge clk);
      end
      if (p == 2) begin
        // receiver holds off while inputs keep coming
        hold_sink = 1;
        for (int i = 0; i < 6; i++) random_item();
        hold_sink = 0;
      end
    end
    quiet = 1;
    for (int i = 0; i < 200; i++) random_item();
    in_ch.valid <= 0;

    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/qoa_pkg.sv
hdl/qoa_if.sv
hdl/qoa_div.sv
hdl/quaternion_orientation_accumulator.sv
bench/qoa_tb_if.sv
bench/orientation_checker.sv
bench/testbench.sv
